[hw/rtl/path_segment_wildcard_match_unit_macros.svh]
// Assertion macros for the path segment wildcard match unit.
// Included by the RTL files that carry concurrent assertions; depends on nothing.
`ifndef PATH_SEGMENT_WILDCARD_MATCH_UNIT_MACROS_SVH
`define PATH_SEGMENT_WILDCARD_MATCH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/psw_pkg.sv]
// Shared types and constants of the path segment wildcard match unit.
// Depends on nothing; used by every RTL module of the unit.
`default_nettype none

package psw_pkg;

    localparam int MAX_SEGMENTS_DEF  = 16;
    localparam int SEGMENT_CHARS_DEF = 255;
    localparam int CHAR_W            = 8;
    localparam int SEG_OUT_W         = 5;

    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;

    typedef enum logic {
        KIND_PATTERN = 1'b0,
        KIND_PATH    = 1'b1
    } t_kind;

    typedef struct packed {
        logic              empty_string;
        logic              last_byte;
        logic [CHAR_W-1:0] ch;
        t_kind             kind;
    } t_item;

    typedef struct packed {
        logic [SEG_OUT_W-1:0] segments_matched;
        logic                 matched;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/psw_ram.sv]
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// A write to the address being read is forwarded to the read data. Uses psw_pkg.
`default_nettype none

module psw_ram #(
    parameter int  DEPTH = psw_pkg::MAX_SEGMENTS_DEF,
    parameter int  DW    = psw_pkg::CHAR_W,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] mem_data [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_data[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= mem_data[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/psw_loader.sv]
// Pattern loader: splits pattern items into segments and writes the character
// and segment stores. Uses psw_pkg.
`default_nettype none

module psw_loader #(
    parameter int  MAX_SEGMENTS  = psw_pkg::MAX_SEGMENTS_DEF,
    parameter int  SEGMENT_CHARS = psw_pkg::SEGMENT_CHARS_DEF,
    localparam int IW   = $clog2(MAX_SEGMENTS + 1),
    localparam int LW   = $clog2(SEGMENT_CHARS + 1),
    localparam int SAW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int CAW  = (MAX_SEGMENTS * SEGMENT_CHARS > 1) ?
                          $clog2(MAX_SEGMENTS * SEGMENT_CHARS) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire psw_pkg::t_item                i_item,
    output logic      [IW-1:0]                 o_pattern_count,
    output logic                               o_char_we,
    output logic      [CAW-1:0]                o_char_waddr,
    output logic      [psw_pkg::CHAR_W-1:0]    o_char_wdata,
    output logic                               o_seg_we,
    output logic      [SAW-1:0]                o_seg_waddr,
    output logic      [LW:0]                   o_seg_wdata
);

    import psw_pkg::*;

    localparam int SUMW = IW + LW + CHAR_W;

    logic              r_load_active, n_load_active;
    logic [IW-1:0]     r_pc, n_pc;
    logic [LW-1:0]     r_lcc, n_lcc;
    logic [CHAR_W-1:0] r_first, n_first;

    logic              w_go, w_pc_ok, w_take, w_slash, w_add, w_store, w_fin;
    logic              w_commit, w_wild;
    logic [IW-1:0]     w_eff_pc;
    logic [LW-1:0]     w_eff_lcc, w_lcc_mid, w_commit_lcc;
    logic [CHAR_W-1:0] w_eff_first, w_first_mid, w_commit_first;
    logic [SUMW-1:0]   w_waddr_full;

    always_comb begin
        w_go        = i_accept && (i_item.kind == KIND_PATTERN);
        w_eff_pc    = r_load_active ? r_pc    : '0;
        w_eff_lcc   = r_load_active ? r_lcc   : '0;
        w_eff_first = r_load_active ? r_first : '0;
        w_pc_ok     = w_eff_pc < IW'(MAX_SEGMENTS);
        w_take      = !i_item.empty_string && w_pc_ok;
        w_slash     = w_take && (i_item.ch == CH_SLASH);
        w_add       = w_take && (i_item.ch != CH_SLASH);
        w_store     = w_add && (w_eff_lcc < LW'(SEGMENT_CHARS));
        w_fin       = i_item.empty_string || i_item.last_byte;

        if (w_slash) begin
            w_lcc_mid = '0;
        end else if (w_store) begin
            w_lcc_mid = w_eff_lcc + LW'(1);
        end else begin
            w_lcc_mid = w_eff_lcc;
        end

        if (w_slash) begin
            w_first_mid = '0;
        end else if (w_add && (w_eff_lcc == '0)) begin
            w_first_mid = i_item.ch;
        end else begin
            w_first_mid = w_eff_first;
        end

        w_commit_lcc   = w_slash ? w_eff_lcc   : w_lcc_mid;
        w_commit_first = w_slash ? w_eff_first : w_first_mid;
        w_commit       = (w_slash || w_fin) && (w_commit_lcc != '0) && w_pc_ok;
        w_wild         = ((w_commit_lcc == LW'(1)) && (w_commit_first == CH_STAR)) ||
                         (w_commit_first == CH_DOLLAR);

        w_waddr_full = SUMW'(w_eff_pc) * SUMW'(SEGMENT_CHARS) + SUMW'(w_eff_lcc);
    end

    always_comb begin
        n_load_active = r_load_active;
        n_pc          = r_pc;
        n_lcc         = r_lcc;
        n_first       = r_first;
        if (w_go) begin
            n_load_active = !w_fin;
            n_pc          = w_eff_pc + IW'(w_commit);
            n_lcc         = w_fin ? '0 : w_lcc_mid;
            n_first       = w_fin ? '0 : w_first_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_active <= 1'b0;
            r_pc          <= '0;
            r_lcc         <= '0;
            r_first       <= '0;
        end else begin
            r_load_active <= n_load_active;
            r_pc          <= n_pc;
            r_lcc         <= n_lcc;
            r_first       <= n_first;
        end
    end

    assign o_pattern_count = r_pc;
    assign o_char_we       = w_go && w_store;
    assign o_char_waddr    = w_waddr_full[CAW-1:0];
    assign o_char_wdata    = i_item.ch;
    assign o_seg_we        = w_go && w_commit;
    assign o_seg_waddr     = w_eff_pc[SAW-1:0];
    assign o_seg_wdata     = {w_wild, w_commit_lcc};

endmodule

`default_nettype wire

[hw/rtl/psw_matcher.sv]
// Path matcher: walks path items against the stored pattern and forms one result
// per path. Prefetches the stores from its next position. Uses psw_pkg and the macros.
`default_nettype none

module psw_matcher #(
    parameter int  MAX_SEGMENTS  = psw_pkg::MAX_SEGMENTS_DEF,
    parameter int  SEGMENT_CHARS = psw_pkg::SEGMENT_CHARS_DEF,
    localparam int IW   = $clog2(MAX_SEGMENTS + 1),
    localparam int LW   = $clog2(SEGMENT_CHARS + 1),
    localparam int SAW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int CAW  = (MAX_SEGMENTS * SEGMENT_CHARS > 1) ?
                          $clog2(MAX_SEGMENTS * SEGMENT_CHARS) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire psw_pkg::t_item             i_item,
    input  wire logic      [IW-1:0]         i_pattern_count,
    input  wire logic [psw_pkg::CHAR_W-1:0] i_rd_char,
    input  wire logic      [LW:0]           i_rd_seg,
    output logic           [CAW-1:0]        o_char_raddr,
    output logic           [SAW-1:0]        o_seg_raddr,
    output logic                            o_res_valid,
    output psw_pkg::t_result                o_res
);

    import psw_pkg::*;

    `include "path_segment_wildcard_match_unit_macros.svh"

    localparam int PCW  = $clog2(SEGMENT_CHARS + 2);
    localparam int SUMW = IW + PCW + CHAR_W;

    logic [IW-1:0]  r_idx, n_idx;
    logic [PCW-1:0] r_cnt, n_cnt;
    logic           r_mism, n_mism;
    logic           r_failed, n_failed;

    logic           w_go, w_fin, w_is_slash, w_in_range, w_wild;
    logic [PCW-1:0] w_len;
    logic [IW-1:0]  w_idx2;
    logic [PCW-1:0] w_cnt1, w_cnt2;
    logic           w_mism1, w_mism2, w_fail1, w_fail2;
    logic [IW+SEG_OUT_W-1:0] w_idx_ext;
    logic [SUMW-1:0] w_raddr_full;

    always_comb begin
        w_go       = i_accept && (i_item.kind == KIND_PATH);
        w_fin      = i_item.empty_string || i_item.last_byte;
        w_is_slash = !i_item.empty_string && (i_item.ch == CH_SLASH);
        w_in_range = r_idx < i_pattern_count;
        w_wild     = i_rd_seg[LW];
        w_len      = PCW'(i_rd_seg[LW-1:0]);

        w_cnt1  = r_cnt;
        w_mism1 = r_mism;
        w_fail1 = r_failed;
        if (!i_item.empty_string && !w_is_slash && !r_failed) begin
            if (!w_in_range) begin
                w_fail1 = 1'b1;
            end else begin
                if (!w_wild) begin
                    if (r_cnt >= w_len) begin
                        w_mism1 = 1'b1;
                    end else if (i_rd_char != i_item.ch) begin
                        w_mism1 = 1'b1;
                    end
                end
                if (r_cnt <= PCW'(SEGMENT_CHARS)) begin
                    w_cnt1 = r_cnt + PCW'(1);
                end
            end
        end

        w_idx2  = r_idx;
        w_cnt2  = w_cnt1;
        w_mism2 = w_mism1;
        w_fail2 = w_fail1;
        if (w_is_slash || w_fin) begin
            if ((w_cnt1 != '0) && !w_fail1) begin
                if (!w_in_range) begin
                    w_fail2 = 1'b1;
                end else if (!w_wild && (w_mism1 || (w_cnt1 != w_len))) begin
                    w_fail2 = 1'b1;
                end else begin
                    w_idx2 = r_idx + IW'(1);
                end
            end
            w_cnt2  = '0;
            w_mism2 = 1'b0;
        end

        w_idx_ext = (IW + SEG_OUT_W)'(w_idx2);
    end

    always_comb begin
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_mism   = r_mism;
        n_failed = r_failed;
        if (i_accept) begin
            if ((i_item.kind == KIND_PATTERN) || w_fin) begin
                n_idx    = '0;
                n_cnt    = '0;
                n_mism   = 1'b0;
                n_failed = 1'b0;
            end else begin
                n_idx    = w_idx2;
                n_cnt    = w_cnt2;
                n_mism   = w_mism2;
                n_failed = w_fail2;
            end
        end
        w_raddr_full = SUMW'(n_idx) * SUMW'(SEGMENT_CHARS) + SUMW'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_cnt    <= '0;
            r_mism   <= 1'b0;
            r_failed <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_mism   <= n_mism;
            r_failed <= n_failed;
        end
    end

    assign o_char_raddr           = w_raddr_full[CAW-1:0];
    assign o_seg_raddr            = n_idx[SAW-1:0];
    assign o_res_valid            = w_go && w_fin;
    assign o_res.matched          = (i_pattern_count != '0) && !w_fail2 &&
                                    (w_idx2 == i_pattern_count);
    assign o_res.segments_matched = w_idx_ext[SEG_OUT_W-1:0];

    `PSW_ASSERT_SAME(a_idx_within_pattern, i_clk, i_rst_n, 1'b1,
        r_idx <= i_pattern_count, "path index passed the stored segment count")
    `PSW_ASSERT_SAME(a_failed_no_count, i_clk, i_rst_n, r_failed,
        r_cnt == '0, "failed path still counts characters")
    `PSW_ASSERT_SAME(a_mismatch_has_chars, i_clk, i_rst_n, r_mism,
        r_cnt != '0, "segment mismatch flagged with no characters")

endmodule

`default_nettype wire

[hw/rtl/path_segment_wildcard_match_unit.sv]
// Top level of the path segment wildcard match unit: stores, loader, matcher and
// a two-entry output stage. Uses psw_pkg, psw_ram, psw_loader, psw_matcher, the macros.
// The unit takes one item per clock cycle on its input stream, pattern and path bytes
// alike, whenever the skid entry is empty, and returns one registered result item for
// each path once its final item is accepted. The stored pattern characters sit in a
// memory of MAX_SEGMENTS times SEGMENT_CHARS bytes and the segment lengths and wildcard
// flags in a memory of MAX_SEGMENTS entries; both are read ahead from the matcher's
// next position, and a pattern write to the entry being read is forwarded, so the single
// memory read port sets the rate of one byte per cycle. The stores need no clearing
// after reset. Input tdata carries the character, tlast ends a string and tuser holds
// the kind (0 pattern, 1 path) and the empty-string flag. An output register with a skid
// entry lets input continue while a result waits to be taken.
`default_nettype none

module path_segment_wildcard_match_unit #(
    parameter int MAX_SEGMENTS  = psw_pkg::MAX_SEGMENTS_DEF,
    parameter int SEGMENT_CHARS = psw_pkg::SEGMENT_CHARS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,  // [7:0] ch
    input  wire logic       i_s_axis_tlast,
    input  wire logic [1:0] i_s_axis_tuser,  // [0] kind, [1] empty_string
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic      [7:0] o_m_axis_tdata   // [0] matched, [5:1] segments_matched, [7:6] zero
);

    import psw_pkg::*;

    `include "path_segment_wildcard_match_unit_macros.svh"

    localparam int IW    = $clog2(MAX_SEGMENTS + 1);
    localparam int LW    = $clog2(SEGMENT_CHARS + 1);
    localparam int SAW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CDEP  = MAX_SEGMENTS * SEGMENT_CHARS;
    localparam int CAW   = (CDEP > 1) ? $clog2(CDEP) : 1;

    t_item             w_item;
    logic              w_accept;
    logic [IW-1:0]     w_pattern_count;
    logic              w_char_we;
    logic [CAW-1:0]    w_char_waddr, w_char_raddr;
    logic [CHAR_W-1:0] w_char_wdata, w_char_rdata;
    logic              w_seg_we;
    logic [SAW-1:0]    w_seg_waddr, w_seg_raddr;
    logic [LW:0]       w_seg_wdata, w_seg_rdata;
    logic              w_res_valid;
    t_result           w_res;

    logic              r_out_valid, r_skid_valid;
    t_result           r_out_data, r_skid_data;
    logic              w_out_take;

    assign w_item.kind         = t_kind'(i_s_axis_tuser[0]);
    assign w_item.empty_string = i_s_axis_tuser[1];
    assign w_item.last_byte    = i_s_axis_tlast;
    assign w_item.ch           = i_s_axis_tdata;

    assign o_s_axis_tready = !r_skid_valid;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    psw_loader #(
        .MAX_SEGMENTS  (MAX_SEGMENTS),
        .SEGMENT_CHARS (SEGMENT_CHARS)
    ) u_loader (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_item          (w_item),
        .o_pattern_count (w_pattern_count),
        .o_char_we       (w_char_we),
        .o_char_waddr    (w_char_waddr),
        .o_char_wdata    (w_char_wdata),
        .o_seg_we        (w_seg_we),
        .o_seg_waddr     (w_seg_waddr),
        .o_seg_wdata     (w_seg_wdata)
    );

    psw_ram #(
        .DEPTH (CDEP),
        .DW    (CHAR_W)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (w_char_we),
        .i_waddr (w_char_waddr),
        .i_wdata (w_char_wdata),
        .i_raddr (w_char_raddr),
        .o_rdata (w_char_rdata)
    );

    psw_ram #(
        .DEPTH (MAX_SEGMENTS),
        .DW    (LW + 1)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (w_seg_we),
        .i_waddr (w_seg_waddr),
        .i_wdata (w_seg_wdata),
        .i_raddr (w_seg_raddr),
        .o_rdata (w_seg_rdata)
    );

    psw_matcher #(
        .MAX_SEGMENTS  (MAX_SEGMENTS),
        .SEGMENT_CHARS (SEGMENT_CHARS)
    ) u_matcher (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_item          (w_item),
        .i_pattern_count (w_pattern_count),
        .i_rd_char       (w_char_rdata),
        .i_rd_seg        (w_seg_rdata),
        .o_char_raddr    (w_char_raddr),
        .o_seg_raddr     (w_seg_raddr),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res)
    );

    assign w_out_take = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid || w_out_take) begin
                r_out_data <= w_res;
            end else begin
                r_skid_data <= w_res;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_data.segments_matched, r_out_data.matched};

    `PSW_ASSERT_SAME(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid,
        r_out_valid, "skid entry held while the output register is empty")
    `PSW_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, w_res_valid,
        r_out_valid, "finished path produced no output item")
    `PSW_ASSERT_NEXT(a_result_to_skid, i_clk, i_rst_n,
        w_res_valid && r_out_valid && !i_m_axis_tready,
        r_skid_valid, "result behind a stalled output was not kept in the skid entry")

endmodule

`default_nettype wire

[bench/path_match_checker.sv]
// Checker for the path segment wildcard match unit: watches both streams, predicts
// each match result from the accepted items and compares it with the unit's output.
// Depends on psw_pkg for the item kinds, the special characters and the result layout.
module path_match_checker
    import psw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_item_valid,
    input  wire logic       i_item_ready,
    input  wire logic [7:0] i_item_data,    // [7:0] ch
    input  wire logic       i_item_last,
    input  wire logic [1:0] i_item_user,    // [0] kind, [1] empty_string
    input  wire logic       i_result_valid,
    input  wire logic       i_result_ready,
    input  wire logic [7:0] i_result_data,  // [0] matched, [5:1] segments_matched, [7:6] zero
    output int              o_errors,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEGS  = MAX_SEGMENTS_DEF;
    localparam int CHARS = SEGMENT_CHARS_DEF;

    logic [7:0] stored_chars [0:SEGS*CHARS-1];
    logic [7:0] stored_len [0:SEGS-1];
    logic       stored_wild [0:SEGS-1];
    logic [4:0] stored_count;
    logic [8:0] load_len;
    logic [7:0] load_first;
    logic       load_busy;
    logic [4:0] path_idx;
    logic [8:0] path_len;
    logic       path_diff;
    logic       path_fail;

    t_result expected_matches [$];
    t_result oldest;
    t_result got;
    int      results_seen;

    initial begin
        o_errors = 0;
        o_pending = 0;
        results_seen = 0;
    end

    task automatic report(input string what);
        $display("%0t ns: result %0d: %s", $time, results_seen, what);
        o_errors++;
    endtask

    task automatic clear_path();
        path_idx = '0;
        path_len = '0;
        path_diff = 1'b0;
        path_fail = 1'b0;
    endtask

    task automatic commit_segment();
        if (load_len > 0 && stored_count < SEGS) begin
            stored_len[stored_count] = load_len[7:0];
            stored_wild[stored_count] = (load_len == 1 && load_first == CH_STAR) ||
                                        load_first == CH_DOLLAR;
            stored_count++;
        end
        load_len = '0;
        load_first = '0;
    endtask

    task automatic close_path_segment();
        if (path_len > 0 && !path_fail) begin
            if (path_idx >= stored_count)
                path_fail = 1'b1;
            else if (!stored_wild[path_idx] && (path_diff || path_len != stored_len[path_idx]))
                path_fail = 1'b1;
            else
                path_idx++;
        end
        path_len = '0;
        path_diff = 1'b0;
    endtask

    task automatic absorb_item(input t_kind kind, input logic [7:0] ch, input logic last,
                               input logic empty);
        t_result res;
        if (kind == KIND_PATTERN) begin
            clear_path();
            if (!load_busy) begin
                stored_count = '0;
                load_len = '0;
                load_first = '0;
                load_busy = 1'b1;
            end
            if (!empty && stored_count < SEGS) begin
                if (ch == CH_SLASH) begin
                    commit_segment();
                end else begin
                    if (load_len == 0)
                        load_first = ch;
                    if (load_len < CHARS) begin
                        stored_chars[stored_count * CHARS + load_len] = ch;
                        load_len++;
                    end
                end
            end
            if (empty || last) begin
                commit_segment();
                load_busy = 1'b0;
            end
        end else begin
            if (!empty) begin
                if (ch == CH_SLASH) begin
                    close_path_segment();
                end else if (!path_fail) begin
                    if (path_idx >= stored_count) begin
                        path_fail = 1'b1;
                    end else begin
                        if (!stored_wild[path_idx] &&
                            (path_len >= stored_len[path_idx] ||
                             stored_chars[path_idx * CHARS + path_len] != ch))
                            path_diff = 1'b1;
                        if (path_len <= CHARS)
                            path_len++;
                    end
                end
            end
            if (empty || last) begin
                close_path_segment();
                res.matched = stored_count != 0 && !path_fail && path_idx == stored_count;
                res.segments_matched = path_idx;
                expected_matches.push_back(res);
                clear_path();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_count = '0;
            load_len = '0;
            load_first = '0;
            load_busy = 1'b0;
            clear_path();
            expected_matches.delete();
        end else begin
            if (i_item_valid && i_item_ready)
                absorb_item(t_kind'(i_item_user[0]), i_item_data, i_item_last, i_item_user[1]);
            if (i_result_valid && i_result_ready) begin
                results_seen++;
                got = t_result'(i_result_data[5:0]);
                if (expected_matches.size() == 0) begin
                    report($sformatf("unexpected result 0x%02h", i_result_data));
                end else begin
                    oldest = expected_matches.pop_front();
                    if (got.matched !== oldest.matched)
                        report($sformatf("matched is %0b, expected %0b",
                                         got.matched, oldest.matched));
                    if (got.segments_matched !== oldest.segments_matched)
                        report($sformatf("segments_matched is %0d, expected %0d",
                                         got.segments_matched, oldest.segments_matched));
                    if (i_result_data[7:6] !== 2'b00)
                        report($sformatf("padding bits are %b", i_result_data[7:6]));
                end
            end
        end
        o_pending <= expected_matches.size();
    end

endmodule

[bench/testbench.sv]
// Top of the bench for the path segment wildcard match unit: clock, reset, stimulus
// and verdict. Depends on psw_pkg, the unit and path_match_checker, which does the checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import psw_pkg::*;

    typedef logic [7:0] t_bytes [$];

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1200;
    localparam int SEG_SLOTS    = MAX_SEGMENTS_DEF + 4;
    localparam int LONG_SEG     = SEGMENT_CHARS_DEF + 3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data = '0;
    logic       s_last = 1'b0;
    logic [1:0] s_user = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data;
    int         errors;
    int         pending;

    int         burst_left = 0;
    int         items_sent = 0;
    int         hold_asked = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    logic [8:0] rx_cycle = '0;
    int         quiet = 0;

    logic [7:0] seg_text [0:SEG_SLOTS-1][0:LONG_SEG-1];
    int         seg_size [0:SEG_SLOTS-1];
    bit         seg_wild [0:SEG_SLOTS-1];
    int         seg_total = 0;

    path_segment_wildcard_match_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    path_match_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_item_valid   (s_valid),
        .i_item_ready   (s_ready),
        .i_item_data    (s_data),
        .i_item_last    (s_last),
        .i_item_user    (s_user),
        .i_result_valid (m_valid),
        .i_result_ready (m_ready),
        .i_result_data  (m_data),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            case (rx_cycle[8:7])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= 1'($urandom_range(0, 1));
                2'd2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input t_kind kind, input logic [7:0] ch, input logic last,
                             input logic empty);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
        end
        s_valid <= 1'b1;
        s_data <= ch;
        s_last <= last;
        s_user <= {empty, kind};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic send_string(input t_kind kind, input t_bytes text);
        bit close_empty;
        close_empty = ($urandom_range(0, 9) == 0);
        foreach (text[i])
            send_item(kind, text[i], (i == text.size() - 1) && !close_empty, 1'b0);
        if (text.size() == 0 || close_empty)
            send_item(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 3))
                0: c = "a";
                1: c = "b";
                2: c = CH_STAR;
                default: c = CH_DOLLAR;
            endcase
        end else begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_SLASH);
        end
        return c;
    endfunction

    task automatic make_pattern(input bit long_one, output t_bytes text);
        int len;
        text = {};
        case ($urandom_range(0, 19))
            0: seg_total = 0;
            1, 2: seg_total = $urandom_range(MAX_SEGMENTS_DEF + 1, SEG_SLOTS);
            default: seg_total = $urandom_range(1, 5);
        endcase
        if (long_one)
            seg_total = 2;
        if ($urandom_range(0, 3) == 0)
            text.push_back(CH_SLASH);
        for (int i = 0; i < seg_total; i++) begin
            len = (long_one && i == 0) ? LONG_SEG : $urandom_range(1, 4);
            for (int j = 0; j < len; j++)
                seg_text[i][j] = body_char();
            if (!long_one && $urandom_range(0, 5) == 0) begin
                len = 1;
                seg_text[i][0] = CH_STAR;
            end
            seg_size[i] = len;
            seg_wild[i] = (len == 1 && seg_text[i][0] == CH_STAR) || seg_text[i][0] == CH_DOLLAR;
            for (int j = 0; j < len; j++)
                text.push_back(seg_text[i][j]);
            if (i < seg_total - 1)
                repeat (($urandom_range(0, 3) == 0) ? 2 : 1) text.push_back(CH_SLASH);
        end
        if ($urandom_range(0, 3) == 0)
            text.push_back(CH_SLASH);
    endtask

    task automatic make_path(input bit full_copy, output t_bytes text);
        t_bytes part;
        int nseg, flaw, spot, keep;
        text = {};
        flaw = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        nseg = seg_total;
        if (flaw == 1 && nseg > 0)
            nseg--;
        if (flaw == 2)
            nseg++;
        spot = $urandom_range(0, (nseg > 0) ? nseg - 1 : 0);
        if (flaw == 5)
            return;
        if (flaw == 6) begin
            repeat ($urandom_range(1, 8))
                text.push_back(($urandom_range(0, 3) == 0) ? CH_SLASH : body_char());
            return;
        end
        if ($urandom_range(0, 3) == 0)
            text.push_back(CH_SLASH);
        for (int i = 0; i < nseg; i++) begin
            part = {};
            if (i >= seg_total || seg_wild[i]) begin
                repeat ($urandom_range(1, 4)) part.push_back(body_char());
            end else begin
                keep = (full_copy || seg_size[i] < SEGMENT_CHARS_DEF) ?
                       seg_size[i] : SEGMENT_CHARS_DEF;
                for (int j = 0; j < keep; j++)
                    part.push_back(seg_text[i][j]);
            end
            if (i == spot && flaw == 3)
                part[$urandom_range(0, part.size() - 1)] = body_char();
            if (i == spot && flaw == 4) begin
                if ($urandom_range(0, 1) == 0 && part.size() > 1)
                    part.delete(part.size() - 1);
                else
                    part.push_back(body_char());
            end
            text = {text, part};
            if (i < nseg - 1)
                repeat (($urandom_range(0, 3) == 0) ? 2 : 1) text.push_back(CH_SLASH);
        end
        if ($urandom_range(0, 4) == 0)
            text.push_back(CH_SLASH);
    endtask

    task automatic run_round(input bit long_one, input int paths);
        t_bytes text;
        t_bytes path;
        int cut;
        make_pattern(long_one, text);
        if (!long_one && text.size() > 2 && $urandom_range(0, 5) == 0) begin
            // A path arrives half-way through the pattern load.
            cut = $urandom_range(1, text.size() - 1);
            for (int i = 0; i < cut; i++)
                send_item(KIND_PATTERN, text[i], 1'b0, 1'b0);
            make_path(1'b0, path);
            send_string(KIND_PATH, path);
            text = text[cut:$];
        end
        send_string(KIND_PATTERN, text);
        for (int p = 0; p < paths; p++) begin
            make_path(long_one ? p[0] : 1'($urandom_range(0, 1)), path);
            send_string(KIND_PATH, path);
        end
        if (!long_one && $urandom_range(0, 3) == 0) begin
            // An unfinished path, dropped by the next pattern load.
            make_path(1'b0, path);
            foreach (path[i])
                send_item(KIND_PATH, path[i], 1'b0, 1'b0);
        end
    endtask

    initial begin
        t_bytes text;
        int round, start;
        round = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // No pattern yet: a path and an empty path both fail.
        send_item(KIND_PATH, "a", 1'b1, 1'b0);
        send_item(KIND_PATH, 8'hFF, 1'b1, 1'b1);
        // Leading and doubled slashes, a lone star, a dollar and character zero.
        text = {CH_SLASH, CH_STAR, CH_SLASH, CH_SLASH, CH_DOLLAR, CH_SLASH, 8'h00, 8'hFF};
        foreach (text[i])
            send_item(KIND_PATTERN, text[i], i == text.size() - 1, 1'b0);
        text = {"q", CH_SLASH, "z", CH_SLASH, 8'h00, 8'hFF};
        foreach (text[i])
            send_item(KIND_PATH, text[i], i == text.size() - 1, 1'b0);
        // A path in the middle of a pattern load sees only the committed segment.
        send_item(KIND_PATTERN, "a", 1'b0, 1'b0);
        send_item(KIND_PATTERN, CH_SLASH, 1'b0, 1'b0);
        send_item(KIND_PATH, "a", 1'b1, 1'b0);
        send_item(KIND_PATTERN, "b", 1'b1, 1'b0);
        // A pattern item drops the unfinished path; an empty string leaves no pattern.
        send_item(KIND_PATH, "a", 1'b0, 1'b0);
        send_item(KIND_PATH, CH_SLASH, 1'b0, 1'b0);
        send_item(KIND_PATTERN, 8'h55, 1'b0, 1'b1);
        send_item(KIND_PATH, "x", 1'b0, 1'b0);
        send_item(KIND_PATH, 8'h00, 1'b1, 1'b1);
        wait_drained();

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            round++;
            if (round == 3) begin
                run_round(1'b1, 2);
            end else begin
                run_round(1'b0, (round == 2 || round == 10) ? 10 : $urandom_range(2, 7));
            end
            if (round == 1 || round == 9)
                hold_asked <= hold_asked + 1;
            if (round % 5 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/psw_pkg.sv
hw/rtl/psw_ram.sv
hw/rtl/psw_loader.sv
hw/rtl/psw_matcher.sv
hw/rtl/path_segment_wildcard_match_unit.sv
bench/path_match_checker.sv
bench/testbench.sv
